// File: rtl/ils_pkg.sv
// Package for the indexed list store: request and status codes, field widths
// and the control group that is broadcast to every storage cell.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package ils_pkg;

	localparam int VALUE_W    = 32;
	localparam int INDEX_W    = 7;
	localparam int LENGTH_W   = 7;
	localparam int REQ_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int GROUP_SIZE = 8;

	localparam logic [REQ_W-1:0] REQ_READ       = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_HEAD   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_TAIL   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INS_BEFORE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

// File: rtl/ils_cell.sv
// One storage cell of the indexed list store: holds a single entry and takes
// its left or right neighbour on a shift. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_cell #(
	parameter int K  = 0,
	parameter int IW = 7
) (
	input  logic                              clk,
	input  ils_pkg::cell_ctrl_t               ctrl,
	input  logic [IW-1:0]                     pos,
	input  logic [ils_pkg::VALUE_W-1:0]       value,
	input  logic [ils_pkg::VALUE_W-1:0]       left,
	input  logic [ils_pkg::VALUE_W-1:0]       right,
	output logic [ils_pkg::VALUE_W-1:0]       data,
	output logic [ils_pkg::VALUE_W-1:0]       rd_data
);

	localparam logic [IW-1:0] K_IDX = IW'(K);

	logic [ils_pkg::VALUE_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (K_IDX > pos) begin
				entry_q <= left;
			end else if (K_IDX == pos) begin
				entry_q <= value;
			end
		end else if (ctrl.del && K_IDX >= pos) begin
			entry_q <= right;
		end
	end

	assign data    = entry_q;
	assign rd_data = (K_IDX == pos) ? entry_q : '0;

endmodule

// File: rtl/ils_or_group.sv
// Registered first level of the read tree: merges the read outputs of one
// group of cells, of which at most one is non-zero. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_or_group (
	input  logic                                                  clk,
	input  logic                                                  load,
	input  logic [ils_pkg::GROUP_SIZE-1:0][ils_pkg::VALUE_W-1:0]  parts,
	output logic [ils_pkg::VALUE_W-1:0]                           sum_s1
);

	logic [ils_pkg::VALUE_W-1:0] merged;

	always_comb begin
		merged = '0;
		for (int i = 0; i < ils_pkg::GROUP_SIZE; i++) begin
			merged = merged | parts[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_s1 <= merged;
		end
	end

endmodule

// File: rtl/indexed_list_store.sv
// Indexed list store: a row of CAPACITY cells that shift together on insert and delete.
// A result passes the request stage and group OR registers, then the output register.
// One item per cycle unless the output stalls; successful inserts and deletes shift on accept.
// The read merge is a registered OR tree over groups of eight cells followed by one wide OR.
// Reset clears the length and the handshake flags; cell contents stay undefined until written.
// Depends on ils_pkg, ils_cell and ils_or_group.
`timescale 1ns / 1ps

module indexed_list_store #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // index [6:0], value [38:7], zero fill [39]
	input  logic [2:0]  s_tuser,   // req_type [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_value [31:0], length [38:32], zero fill [39]
	output logic [1:0]  m_tuser    // status [1:0]
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > ils_pkg::INDEX_W) ? CW : ils_pkg::INDEX_W;
	localparam int NG = (CAPACITY + ils_pkg::GROUP_SIZE - 1) / ils_pkg::GROUP_SIZE;
	localparam logic [IW-1:0] CAP_W = IW'(CAPACITY);

	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_d;
	logic [IW-1:0]                 count_w;
	logic [IW-1:0]                 idx_w;
	logic [IW-1:0]                 ins_pos;
	logic [IW-1:0]                 cell_pos;
	logic [ils_pkg::REQ_W-1:0]     req;
	logic [ils_pkg::VALUE_W-1:0]   value;
	logic                          accept;
	logic                          is_ins;
	logic                          ins_ok;
	logic                          del_ok;
	logic                          hit;
	logic [ils_pkg::STATUS_W-1:0]  status;
	ils_pkg::cell_ctrl_t           ctrl;

	logic                          valid_s1;
	logic                          adv;
	logic                          hit_s1;
	logic [ils_pkg::STATUS_W-1:0]  status_s1;
	logic [ils_pkg::LENGTH_W-1:0]  length_s1;
	logic                          out_valid_q;
	logic [ils_pkg::STATUS_W-1:0]  status_q;
	logic [ils_pkg::VALUE_W-1:0]   read_value_q;
	logic [ils_pkg::LENGTH_W-1:0]  length_q;
	logic [ils_pkg::VALUE_W-1:0]   merged;

	logic [CAPACITY-1:0][ils_pkg::VALUE_W-1:0]                         cell_data;
	logic [NG*ils_pkg::GROUP_SIZE-1:0][ils_pkg::VALUE_W-1:0]           cell_rd;
	logic [NG-1:0][ils_pkg::VALUE_W-1:0]                               group_s1;

	assign req     = s_tuser;
	assign idx_w   = IW'(s_tdata[6:0]);
	assign value   = s_tdata[38:7];
	assign count_w = IW'(count_q);

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		is_ins  = 1'b0;
		ins_pos = idx_w;
		del_ok  = 1'b0;
		hit     = 1'b0;
		status  = ils_pkg::ST_RANGE;
		unique case (req)
			ils_pkg::REQ_READ: begin
				hit = idx_w < count_w;
				if (hit) begin
					status = ils_pkg::ST_DONE;
				end
			end
			ils_pkg::REQ_INS_HEAD: begin
				is_ins  = 1'b1;
				ins_pos = '0;
			end
			ils_pkg::REQ_INS_TAIL: begin
				is_ins  = 1'b1;
				ins_pos = count_w;
			end
			ils_pkg::REQ_INS_BEFORE: begin
				is_ins = 1'b1;
			end
			ils_pkg::REQ_DELETE: begin
				del_ok = idx_w < count_w;
				if (del_ok) begin
					status = ils_pkg::ST_DONE;
				end
			end
			default: begin
				status = ils_pkg::ST_RANGE;
			end
		endcase
		ins_ok = 1'b0;
		if (is_ins) begin
			priority if (ins_pos > count_w) begin
				status = ils_pkg::ST_RANGE;
			end else if (count_w >= CAP_W) begin
				status = ils_pkg::ST_FULL;
			end else begin
				status = ils_pkg::ST_DONE;
				ins_ok = 1'b1;
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + 1'b1;
		end else if (del_ok) begin
			count_d = count_q - 1'b1;
		end
	end

	assign cell_pos = is_ins ? ins_pos : idx_w;
	assign ctrl.ins = accept && ins_ok;
	assign ctrl.del = accept && del_ok;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [ils_pkg::VALUE_W-1:0] left;
		logic [ils_pkg::VALUE_W-1:0] right;
		if (k == 0) begin : g_head
			assign left = value;
		end else begin : g_body
			assign left = cell_data[k-1];
		end
		if (k == CAPACITY - 1) begin : g_tail
			assign right = cell_data[k];
		end else begin : g_inner
			assign right = cell_data[k+1];
		end
		ils_cell #(
			.K  (k),
			.IW (IW)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.pos     (cell_pos),
			.value   (value),
			.left    (left),
			.right   (right),
			.data    (cell_data[k]),
			.rd_data (cell_rd[k])
		);
	end

	for (genvar k = CAPACITY; k < NG * ils_pkg::GROUP_SIZE; k++) begin : g_pad
		assign cell_rd[k] = '0;
	end

	for (genvar g = 0; g < NG; g++) begin : g_group
		ils_or_group u_group (
			.clk    (clk),
			.load   (accept),
			.parts  (cell_rd[g*ils_pkg::GROUP_SIZE +: ils_pkg::GROUP_SIZE]),
			.sum_s1 (group_s1[g])
		);
	end

	always_comb begin
		merged = '0;
		for (int g = 0; g < NG; g++) begin
			merged = merged | group_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_d;
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1    <= hit;
			status_s1 <= status;
			length_s1 <= ils_pkg::LENGTH_W'(count_d);
		end
		if (adv) begin
			status_q     <= status_s1;
			read_value_q <= hit_s1 ? merged : '1;
			length_q     <= length_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, length_q, read_value_q};
	assign m_tuser  = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("length exceeds capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ins_ok) |=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted insert did not grow the length");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && status_s1 == ils_pkg::ST_FULL) |-> (count_q == CW'(CAPACITY)))
		else $error("full status reported while not full");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("item accepted while the request stage is stalled");

endmodule
